// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the colour combiner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// Types, operation codes and decode for the RGBA8 colour combiner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = NUM_CHAN * CHAN_W;
    localparam int KIND_W   = 4;
    localparam int ALPHA    = NUM_CHAN - 1;

    localparam logic [KIND_W-1:0] KIND_ADD      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_RGB  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_A    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SUB      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SUB_RGB  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SUB_A    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MOD      = 4'd6;
    localparam logic [KIND_W-1:0] KIND_MOD_RGB  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MOD_A    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LERP     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_REPL_A   = 4'd10;

    localparam logic [NUM_CHAN-1:0] MASK_ALL  = 4'b1111;
    localparam logic [NUM_CHAN-1:0] MASK_RGB  = 4'b0111;
    localparam logic [NUM_CHAN-1:0] MASK_A    = 4'b1000;
    localparam logic [NUM_CHAN-1:0] MASK_NONE = 4'b0000;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_MOD  = 2'd2,
        OP_LERP = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [NUM_CHAN-1:0] mask;  // lanes that compute; others pass colour_first
        logic                repl;  // broadcast alpha of colour_first
    } t_ctrl;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] t_chan_vec;

    function automatic t_ctrl decode_kind(input logic [KIND_W-1:0] kind);
        t_ctrl c;
        c.op   = OP_ADD;
        c.mask = MASK_NONE;
        c.repl = 1'b0;
        case (kind)
            KIND_ADD:     begin c.op = OP_ADD;  c.mask = MASK_ALL; end
            KIND_ADD_RGB: begin c.op = OP_ADD;  c.mask = MASK_RGB; end
            KIND_ADD_A:   begin c.op = OP_ADD;  c.mask = MASK_A;   end
            KIND_SUB:     begin c.op = OP_SUB;  c.mask = MASK_ALL; end
            KIND_SUB_RGB: begin c.op = OP_SUB;  c.mask = MASK_RGB; end
            KIND_SUB_A:   begin c.op = OP_SUB;  c.mask = MASK_A;   end
            KIND_MOD:     begin c.op = OP_MOD;  c.mask = MASK_ALL; end
            KIND_MOD_RGB: begin c.op = OP_MOD;  c.mask = MASK_RGB; end
            KIND_MOD_A:   begin c.op = OP_MOD;  c.mask = MASK_A;   end
            KIND_LERP:    begin c.op = OP_LERP; c.mask = MASK_ALL; end
            KIND_REPL_A:  begin c.repl = 1'b1; end
            default:      begin c.mask = MASK_NONE; end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/rcc_lane.sv =====
// ----------------------------------------------------------------------------
// rcc_lane
// One colour channel: add/sub/modulate and lerp product in the first stage,
// the exact floor division by 255 of the lerp term in the second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcc_lane (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  rcc_pkg::t_op                i_op,
    input  logic                        i_act,
    input  logic [rcc_pkg::CHAN_W-1:0]  i_x,
    input  logic [rcc_pkg::CHAN_W-1:0]  i_y,
    input  logic [rcc_pkg::CHAN_W-1:0]  i_w,
    output logic [rcc_pkg::CHAN_W-1:0]  o_chan
);
    import rcc_pkg::*;

    // stage 1
    logic [CHAN_W:0]         w_sum;
    logic [CHAN_W:0]         w_diff;
    logic [2*CHAN_W-1:0]     w_prod;
    logic signed [CHAN_W:0]  w_d;
    logic signed [CHAN_W:0]  w_ws;
    logic signed [2*CHAN_W+1:0] w_p;
    logic [CHAN_W-1:0]       n_res;

    logic [2*CHAN_W:0]       r_p;
    logic [CHAN_W-1:0]       r_res;
    logic [CHAN_W-1:0]       r_x;
    logic                    r_lerp;

    // stage 2
    logic                    w_neg;
    logic [2*CHAN_W:0]       w_mag;
    logic [2*CHAN_W-1:0]     w_n;
    logic [2*CHAN_W-1:0]     w_t;
    logic [CHAN_W-1:0]       w_est;
    logic [2*CHAN_W-1:0]     w_est255;
    logic [2*CHAN_W-1:0]     w_rem;
    logic [CHAN_W-1:0]       w_q;
    logic [CHAN_W-1:0]       w_lerp;

    always_comb begin
        w_sum  = {1'b0, i_x} + {1'b0, i_y};
        w_diff = {1'b0, i_x} - {1'b0, i_y};
        w_prod = i_x * i_y;
        w_d    = $signed({1'b0, i_y}) - $signed({1'b0, i_x});
        w_ws   = $signed({1'b0, i_w});
        w_p    = (2*CHAN_W+2)'(w_d) * (2*CHAN_W+2)'(w_ws);
        n_res  = i_x;
        if (i_act) begin
            case (i_op)
                OP_ADD:  n_res = w_sum[CHAN_W] ? {CHAN_W{1'b1}} : w_sum[CHAN_W-1:0];
                OP_SUB:  n_res = w_diff[CHAN_W] ? '0 : w_diff[CHAN_W-1:0];
                OP_MOD:  n_res = w_prod[2*CHAN_W-1:CHAN_W];
                OP_LERP: n_res = i_x;
                default: n_res = i_x;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p    <= w_p[2*CHAN_W:0];
            r_res  <= n_res;
            r_x    <= i_x;
            r_lerp <= i_act && (i_op == OP_LERP);
        end
    end

    // floor(p/255): for negative p use -floor((|p|+254)/255). Quotient estimate
    // (n + n/256)/256 is at most one low, fixed by one compare on the remainder.
    always_comb begin
        w_neg    = r_p[2*CHAN_W];
        w_mag    = -r_p;
        w_n      = w_neg ? (w_mag[2*CHAN_W-1:0] + 16'd254) : r_p[2*CHAN_W-1:0];
        w_t      = w_n + {{CHAN_W{1'b0}}, w_n[2*CHAN_W-1:CHAN_W]};
        w_est    = w_t[2*CHAN_W-1:CHAN_W];
        w_est255 = {w_est, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, w_est};
        w_rem    = w_n - w_est255;
        w_q      = w_est + {{(CHAN_W-1){1'b0}}, (w_rem >= 16'd255)};
        w_lerp   = w_neg ? (r_x - w_q) : (r_x + w_q);
        o_chan   = r_lerp ? w_lerp : r_res;
    end

endmodule

// ===== rtl/rcc_merge.sv =====
// ----------------------------------------------------------------------------
// rcc_merge
// Packs the lane results into one colour, or broadcasts alpha, into the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcc_merge (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_repl,
    input  rcc_pkg::t_chan_vec            i_chan,
    output logic [rcc_pkg::COLOUR_W-1:0]  o_colour
);
    import rcc_pkg::*;

    logic [COLOUR_W-1:0] n_colour;
    logic [COLOUR_W-1:0] r_colour;

    // alpha lane passes colour_first through when replicating
    assign n_colour = i_repl ? {NUM_CHAN{i_chan[ALPHA]}} : i_chan;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_colour <= n_colour;
        end
    end

    assign o_colour = r_colour;

endmodule

// ===== rtl/rgba8_colour_combiner.sv =====
// ----------------------------------------------------------------------------
// rgba8_colour_combiner
// Per-channel saturating add/sub, modulate, lerp and alpha replicate on
// packed RGBA8 colours, four channel lanes side by side.
// ----------------------------------------------------------------------------
// Channel  Valid        Stall        Payload
// in       i_in_valid   o_in_stall   i_kind, i_colour_first, i_colour_second,
//                                    i_blend_weights
// out      o_out_valid  i_out_stall  o_colour_result
//
// One item per clock sustained while the output is not stalled; registered in the lane
// stage, then in the output register after the lane divide-by-255 and merge.
// Synchronous active-low reset clears only the two valid flags.
// An output stall holds the result; a second stage item is still taken while
// the result waits, so the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgba8_colour_combiner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rcc_pkg::KIND_W-1:0]    i_kind,
    input  logic [rcc_pkg::COLOUR_W-1:0]  i_colour_first,
    input  logic [rcc_pkg::COLOUR_W-1:0]  i_colour_second,
    input  logic [rcc_pkg::COLOUR_W-1:0]  i_blend_weights,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rcc_pkg::COLOUR_W-1:0]  o_colour_result
);
    import rcc_pkg::*;

    t_ctrl     w_ctrl;
    t_chan_vec w_chan;
    logic      w_out_ready;
    logic      w_s1_ready;
    logic      w_acc;
    logic      w_adv;
    logic      r_v1;
    logic      n_v1;
    logic      r_vo;
    logic      n_vo;
    logic      r_repl;

    assign w_ctrl      = decode_kind(i_kind);
    assign w_out_ready = !r_vo || !i_out_stall;
    assign w_s1_ready  = !r_v1 || w_out_ready;
    assign w_acc       = i_in_valid && w_s1_ready;
    assign w_adv       = r_v1 && w_out_ready;

    always_comb begin
        n_v1 = r_v1;
        if (w_acc) begin
            n_v1 = 1'b1;
        end else if (w_adv) begin
            n_v1 = 1'b0;
        end
        n_vo = r_vo;
        if (w_adv) begin
            n_vo = 1'b1;
        end else if (w_out_ready) begin
            n_vo = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_vo <= n_vo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_repl <= w_ctrl.repl;
        end
    end

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        rcc_lane u_lane (
            .i_clk  (i_clk),
            .i_load (w_acc),
            .i_op   (w_ctrl.op),
            .i_act  (w_ctrl.mask[g]),
            .i_x    (i_colour_first[CHAN_W*g +: CHAN_W]),
            .i_y    (i_colour_second[CHAN_W*g +: CHAN_W]),
            .i_w    (i_blend_weights[CHAN_W*g +: CHAN_W]),
            .o_chan (w_chan[g])
        );
    end

    rcc_merge u_merge (
        .i_clk    (i_clk),
        .i_load   (w_adv),
        .i_repl   (r_repl),
        .i_chan   (w_chan),
        .o_colour (o_colour_result)
    );

    assign o_in_stall  = !w_s1_ready;
    assign o_out_valid = r_vo;

    `AST_IMPLIES(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_v1 && r_vo && i_out_stall, "input stalled with room in the pipeline")
    `AST_NEXT(a_acc_fills_s1, i_clk, i_rst_n, w_acc, r_v1, "accepted transfer lost before lane stage")
    `AST_NEXT(a_s1_reaches_out, i_clk, i_rst_n, r_v1 && !(r_vo && i_out_stall), r_vo, "lane stage result did not reach output register")

endmodule

// ===== verif/tb_rgba8_colour_combiner.sv =====
// ----------------------------------------------------------------------------
// tb_rgba8_colour_combiner
// Self-checking bench for the RGBA8 colour combiner. A directed table covers
// the channel extremes, every operation, lerp rounding and the unused codes;
// about 450 random transfers follow, sent in bursts while the output side
// stalls in changing patterns. Every result is checked in order against a
// typed-in result or a per-channel colour predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgba8_colour_combiner;

    import rcc_pkg::*;

    localparam int NUM_DIRECTED = 23;
    localparam int NUM_RANDOM   = 450;

    // codes the block does not define; the first colour passes through
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_REPL_A + 4'd1;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'hF;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [COLOUR_W-1:0] first;
        logic [COLOUR_W-1:0] second;
        logic [COLOUR_W-1:0] weights;
        logic                known;   // result typed in below
        logic [COLOUR_W-1:0] result;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind          = '0;
    logic [COLOUR_W-1:0] i_colour_first  = '0;
    logic [COLOUR_W-1:0] i_colour_second = '0;
    logic [COLOUR_W-1:0] i_blend_weights = '0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic [COLOUR_W-1:0] o_colour_result;

    // travels with the payload: typed-in result for directed rows
    logic                in_known        = 1'b0;
    logic [COLOUR_W-1:0] in_known_result = '0;

    logic [COLOUR_W-1:0] expected_colours [$];
    int                  mismatch_count = 0;

    t_stall_mode         stall_mode = STALL_NONE;
    int                  stall_span = 0;
    logic [2:0]          stall_tick = '0;

    t_directed_row       directed_rows [0:NUM_DIRECTED-1];

    rgba8_colour_combiner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_colour_first  (i_colour_first),
        .i_colour_second (i_colour_second),
        .i_blend_weights (i_blend_weights),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_colour_result (o_colour_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [COLOUR_W-1:0] predict_colour(
        input logic [KIND_W-1:0]   kind,
        input logic [COLOUR_W-1:0] first,
        input logic [COLOUR_W-1:0] second,
        input logic [COLOUR_W-1:0] weights
    );
        t_op                 op;
        logic [NUM_CHAN-1:0] lanes;
        logic [CHAN_W-1:0]   a, b, w, v;
        logic [CHAN_W:0]     sum;
        logic [2*CHAN_W-1:0] prod;
        int                  diff, scaled, quot;
        logic [COLOUR_W-1:0] res;

        if (kind == KIND_REPL_A) begin
            return {NUM_CHAN{first[COLOUR_W-1 -: CHAN_W]}};
        end
        case (kind)
            KIND_ADD, KIND_ADD_RGB, KIND_ADD_A: op = OP_ADD;
            KIND_SUB, KIND_SUB_RGB, KIND_SUB_A: op = OP_SUB;
            KIND_MOD, KIND_MOD_RGB, KIND_MOD_A: op = OP_MOD;
            default:                            op = OP_LERP;
        endcase
        case (kind)
            KIND_ADD, KIND_SUB, KIND_MOD, KIND_LERP:    lanes = MASK_ALL;
            KIND_ADD_RGB, KIND_SUB_RGB, KIND_MOD_RGB:   lanes = MASK_RGB;
            KIND_ADD_A, KIND_SUB_A, KIND_MOD_A:         lanes = MASK_A;
            default:                                    lanes = MASK_NONE;
        endcase
        res = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            a = first[CHAN_W*ch +: CHAN_W];
            b = second[CHAN_W*ch +: CHAN_W];
            w = weights[CHAN_W*ch +: CHAN_W];
            v = a;
            if (lanes[ch]) begin
                case (op)
                    OP_ADD: begin
                        sum = {1'b0, a} + {1'b0, b};
                        v = sum[CHAN_W] ? 8'hFF : sum[CHAN_W-1:0];
                    end
                    OP_SUB: v = (a > b) ? a - b : 8'h00;
                    OP_MOD: begin
                        prod = a * b;
                        v = prod[2*CHAN_W-1:CHAN_W];
                    end
                    default: begin
                        // floor division by 255, also for negative products
                        diff   = int'(b) - int'(a);
                        scaled = diff * int'(w);
                        if (scaled >= 0)
                            quot = scaled / 255;
                        else
                            quot = -((-scaled + 254) / 255);
                        v = 8'(int'(a) + quot);
                    end
                endcase
            end
            res[CHAN_W*ch +: CHAN_W] = v;
        end
        return res;
    endfunction

    function automatic logic [COLOUR_W-1:0] random_colour();
        logic [COLOUR_W-1:0] c;
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            case ($urandom_range(0, 5))
                0:       c[CHAN_W*ch +: CHAN_W] = 8'h00;
                1:       c[CHAN_W*ch +: CHAN_W] = 8'hFF;
                2:       c[CHAN_W*ch +: CHAN_W] = 8'h01;
                3:       c[CHAN_W*ch +: CHAN_W] = 8'hFE;
                default: c[CHAN_W*ch +: CHAN_W] = 8'($urandom);
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [COLOUR_W-1:0] want,
                                   input logic [COLOUR_W-1:0] got);
        $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_colour_op(
        input logic [KIND_W-1:0]   kind,
        input logic [COLOUR_W-1:0] first,
        input logic [COLOUR_W-1:0] second,
        input logic [COLOUR_W-1:0] weights,
        input logic                known,
        input logic [COLOUR_W-1:0] result
    );
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_colour_first  <= first;
        i_colour_second <= second;
        i_blend_weights <= weights;
        in_known        <= known;
        in_known_result <= result;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
    endtask

    // Output check first, then record the transfer accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_colours.size() == 0)
                    report_mismatch("result with no transfer pending", '0, o_colour_result);
                else if (o_colour_result !== expected_colours[0])
                    report_mismatch("colour_result", expected_colours.pop_front(),
                                    o_colour_result);
                else
                    void'(expected_colours.pop_front());
            end
            if (i_in_valid && !o_in_stall) begin
                if (in_known)
                    expected_colours.push_back(in_known_result);
                else
                    expected_colours.push_back(predict_colour(i_kind, i_colour_first,
                                                              i_colour_second,
                                                              i_blend_weights));
            end
        end
    end

    // Output stall: each random mode holds for a random span before a new one is picked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 3'd1;
            if (stall_span == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                stall_span <= $urandom_range(8, 60);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= stall_tick[2] ^ stall_tick[0];
            endcase
        end
    end

    initial begin
        logic [KIND_W-1:0] kind;
        int                burst_left;

        directed_rows = '{
            '{KIND_ADD,       32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
            '{KIND_ADD,       32'h00000000, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000},
            '{KIND_ADD,       32'h80FF017F, 32'h80010100, 32'hA5A5A5A5, 1'b0, 32'h0},
            '{KIND_ADD_RGB,   32'h10FFF0E0, 32'hFF102030, 32'h00000000, 1'b0, 32'h0},
            '{KIND_ADD_A,     32'hF0123456, 32'h20FFFFFF, 32'h00000000, 1'b0, 32'h0},
            '{KIND_SUB,       32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000},
            '{KIND_SUB,       32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
            '{KIND_SUB,       32'h7F018040, 32'h80018020, 32'h00000000, 1'b0, 32'h0},
            '{KIND_SUB_RGB,   32'h20103050, 32'h40204010, 32'h00000000, 1'b0, 32'h0},
            '{KIND_SUB_A,     32'h10AABBCC, 32'h20000000, 32'h00000000, 1'b0, 32'h0},
            '{KIND_MOD,       32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFEFEFEFE},
            '{KIND_MOD,       32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
            '{KIND_MOD_RGB,   32'h80FF8040, 32'hFF80FF02, 32'h00000000, 1'b0, 32'h0},
            '{KIND_MOD_A,     32'h80112233, 32'h80445566, 32'h00000000, 1'b0, 32'h0},
            '{KIND_LERP,      32'h12345678, 32'h9ABCDEF0, 32'h00000000, 1'b1, 32'h12345678},
            '{KIND_LERP,      32'h12345678, 32'h9ABCDEF0, 32'hFFFFFFFF, 1'b1, 32'h9ABCDEF0},
            '{KIND_LERP,      32'h00FF00FF, 32'hFF00FF00, 32'h01010101, 1'b0, 32'h0},
            '{KIND_LERP,      32'h10203040, 32'hF0E0D0C0, 32'h80407FC0, 1'b0, 32'h0},
            '{KIND_REPL_A,    32'hAB123456, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hABABABAB},
            '{KIND_REPL_A,    32'h00FFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000},
            '{KIND_UNUSED_LO, 32'hDEADBEEF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hDEADBEEF},
            '{KIND_UNUSED_LO + 4'd2,
                              32'h01234567, 32'h00000000, 32'h00000000, 1'b1, 32'h01234567},
            '{KIND_UNUSED_HI, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < NUM_DIRECTED; row++) begin
            send_colour_op(directed_rows[row].kind, directed_rows[row].first,
                           directed_rows[row].second, directed_rows[row].weights,
                           directed_rows[row].known, directed_rows[row].result);
        end

        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            if ($urandom_range(0, 99) < 88)
                kind = KIND_W'($urandom_range(KIND_ADD, KIND_REPL_A));
            else
                kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            send_colour_op(kind, random_colour(), random_colour(), random_colour(),
                           1'b0, '0);
            burst_left--;
        end
        i_in_valid <= 1'b0;

        while (expected_colours.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && expected_colours.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
